// ===== hdl/ecpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ecpa_pkg
// Shared types, register indexes and fixed-point constants of the European
// call payoff accumulator.
// ----------------------------------------------------------------------------
package ecpa_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPOT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATURITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd5;

  // register reset values
  localparam logic [31:0]        SPOT_RST     = 32'd6553600;
  localparam logic [31:0]        STRIKE_RST   = 32'd6553600;
  localparam logic [23:0]        MATURITY_RST = 24'd65536;
  localparam logic signed [17:0] RATE_RST     = 18'sd3277;
  localparam logic [17:0]        VOL_RST      = 18'd13107;
  localparam logic [31:0]        COUNT_RST    = 32'd1;

  // fixed-point constants
  localparam logic [31:0]        PRICE_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0]        ONE_Q30   = 32'd1073741824;
  localparam logic [30:0]        LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0]        LN2_Q30   = 30'd744261118;
  localparam logic signed [23:0] X_LIMIT   = 24'sd4194304;
  localparam logic [3:0]         HORNER_K0 = 4'd12;

  typedef struct packed {
    logic [31:0]        spot;
    logic [31:0]        strike;
    logic [23:0]        maturity;
    logic signed [17:0] rate;
    logic [17:0]        vol;
    logic [31:0]        count;
  } ecpa_cfg_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic              valid;
    logic signed [15:0] sample;
  } ecpa_head_t;

endpackage

// ===== hdl/ecpa_sample_if.sv =====
// ----------------------------------------------------------------------------
// ecpa_sample_if
// Request channel carrying one standard normal sample.
// ----------------------------------------------------------------------------
interface ecpa_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_sample;

  modport source (output valid, output normal_sample, input ready);
  modport sink (input valid, input normal_sample, output ready);
endinterface

// ===== hdl/ecpa_result_if.sv =====
// ----------------------------------------------------------------------------
// ecpa_result_if
// Request channel carrying one run's payoff sum and saturation flag.
// ----------------------------------------------------------------------------
interface ecpa_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] payoff_sum;
  logic        sum_saturated;

  modport source (output valid, output payoff_sum, output sum_saturated, input ready);
  modport sink (input valid, input payoff_sum, input sum_saturated, output ready);
endinterface

// ===== hdl/european_call_payoff_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// european_call_payoff_accumulator_top
// Monte Carlo European call kernel: prices each normal sample and sums the
// call payoffs of a run.
// ----------------------------------------------------------------------------
// A sample's work is set mostly by the exp series: twelve Horner steps,
// each a multiply and a reciprocal multiplication in two halves for the
// divide by the step index. The first sample of a run also works out
// the drift and the 28-step square root of the maturity. Samples are
// taken into a two-entry queue while the previous one is in work, and a
// finished run sum waits in an output register until taken.
// Write the registers only while no sample is in work.
module european_call_payoff_accumulator_top
  import ecpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ecpa_sample_if.sink           sample_in,
  ecpa_result_if.source         result_out
);

  ecpa_cfg_t  cfg;
  ecpa_head_t head;
  logic       pop;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spot     <= SPOT_RST;
      cfg.strike   <= STRIKE_RST;
      cfg.maturity <= MATURITY_RST;
      cfg.rate     <= RATE_RST;
      cfg.vol      <= VOL_RST;
      cfg.count    <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPOT:     cfg.spot     <= cfg_data;
        REG_STRIKE:   cfg.strike   <= cfg_data;
        REG_MATURITY: cfg.maturity <= cfg_data[23:0];
        REG_RATE:     cfg.rate     <= $signed(cfg_data[17:0]);
        REG_VOL:      cfg.vol      <= cfg_data[17:0];
        REG_COUNT:    cfg.count    <= cfg_data;
        default: ;
      endcase
    end
  end

  ecpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_in),
    .head      (head),
    .pop       (pop)
  );

  ecpa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

// ===== hdl/ecpa_front.sv =====
// ----------------------------------------------------------------------------
// ecpa_front
// Input side: accepts sample requests into a two-entry queue that the back
// end drains at its own pace.
// ----------------------------------------------------------------------------
module ecpa_front
  import ecpa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ecpa_sample_if.sink  sample_in,
  output ecpa_head_t   head,
  input  logic         pop
);

  logic signed [15:0] slot [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  logic               take;

  assign sample_in.ready = (count != 2'd2);
  assign push = sample_in.valid && sample_in.ready;
  assign take = pop && (count != 2'd0);

  assign head.valid  = (count != 2'd0);
  assign head.sample = slot[rd_ptr];

  // store incoming samples
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= sample_in.normal_sample;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, take};
    end
  end

endmodule

// ===== hdl/ecpa_back.sv =====
// ----------------------------------------------------------------------------
// ecpa_back
// Execution side: sequencer that derives drift and scaled volatility at run
// start, prices each sample through exp, and accumulates call payoffs.
// ----------------------------------------------------------------------------
module ecpa_back
  import ecpa_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  ecpa_cfg_t     cfg,
  input  ecpa_head_t    head,
  output logic          pop,
  ecpa_result_if.source result_out
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_D    = 4'd1;
  localparam logic [3:0] S_DT   = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_SV   = 4'd4;
  localparam logic [3:0] S_MZ   = 4'd5;
  localparam logic [3:0] S_X    = 4'd6;
  localparam logic [3:0] S_Y    = 4'd7;
  localparam logic [3:0] S_T    = 4'd8;
  localparam logic [3:0] S_H    = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_P    = 4'd11;
  localparam logic [3:0] S_SH   = 4'd12;
  localparam logic [3:0] S_ACC  = 4'd13;
  localparam logic [3:0] S_DIV2 = 4'd14;

  // shift right by s, rounding half away from zero
  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic [63:0] m;
    begin
      m = v[63] ? (64'd0 - v) : v;
      m = (m + (64'd1 << (s - 1))) >> s;
      shr_round = v[63] ? $signed(64'd0 - m) : $signed(m);
    end
  endfunction

  logic [3:0]         state;
  logic signed [15:0] z;
  logic signed [37:0] d;
  logic signed [31:0] drift;
  logic [31:0]        sv;
  logic [55:0]        sq_rem;
  logic [55:0]        sq_res;
  logic [55:0]        sq_bit;
  logic signed [48:0] mz;
  logic signed [23:0] x;
  logic signed [9:0]  n;
  logic [29:0]        u;
  logic [29:0]        t;
  logic [31:0]        hacc;
  logic [3:0]         k;
  logic [31:0]        dvd;
  logic [49:0]        plo;
  logic [63:0]        p;
  logic [31:0]        st;
  logic [63:0]        accum;
  logic [31:0]        seen;
  logic               sat;
  logic               res_vld;
  logic [63:0]        res_sum;
  logic               res_sat;

  // combinational helpers
  logic signed [62:0] dt_prod;
  logic signed [63:0] drift_w;
  logic [55:0]        sq_try;
  logic [47:0]        sv_w;
  logic signed [63:0] x_w;
  logic signed [55:0] y_w;
  logic [59:0]        t_w;
  logic [61:0]        h_w;
  logic [35:0]        mag;
  logic [49:0]        phi_w;
  logic [67:0]        q_w;
  logic signed [10:0] sh;
  logic [5:0]         lsh;
  logic [64:0]        rnd_w;
  logic [31:0]        st_next;
  logic               st_of;
  logic [63:0]        payoff;
  logic [64:0]        sum_w;
  logic [63:0]        accum_next;
  logic               sat_next;
  logic [31:0]        seen_next;
  logic               run_done;
  logic               slot_free;
  logic               res_load;

  assign result_out.valid         = res_vld;
  assign result_out.payoff_sum    = res_sum;
  assign result_out.sum_saturated = res_sat;

  assign pop = (state == S_IDLE) && head.valid;

  // run-start arithmetic
  assign dt_prod = d * $signed({1'b0, cfg.maturity});
  assign drift_w = shr_round({{1{dt_prod[62]}}, dt_prod}, 33);
  assign sq_try  = sq_res + sq_bit;
  assign sv_w    = ({30'd0, cfg.vol} * {19'd0, sq_res[28:0]}) + 48'd8388608;

  // per-sample exponent
  assign x_w = {{32{drift[31]}}, drift} + shr_round({{15{mz[48]}}, mz}, 12);
  assign y_w = x * $signed({1'b0, LOG2E_Q30});
  assign t_w = u * LN2_Q30;
  assign h_w = hacc * t;

  // reciprocal of the Horner index, ceil(2^35 / k); exact for dividends below 2^31
  always_comb begin
    unique case (k)
      4'd1:    mag = 36'd34359738368;
      4'd2:    mag = 36'd17179869184;
      4'd3:    mag = 36'd11453246123;
      4'd4:    mag = 36'd8589934592;
      4'd5:    mag = 36'd6871947674;
      4'd6:    mag = 36'd5726623062;
      4'd7:    mag = 36'd4908534053;
      4'd8:    mag = 36'd4294967296;
      4'd9:    mag = 36'd3817748708;
      4'd10:   mag = 36'd3435973837;
      4'd11:   mag = 36'd3123612579;
      4'd12:   mag = 36'd2863311531;
      default: mag = 36'd0;
    endcase
  end

  // upper half of the reciprocal product, joined with the registered lower half
  assign phi_w = dvd * mag[35:18];
  assign q_w   = {18'd0, plo} + {phi_w, 18'd0};

  // scale by 2^n with rounding and saturation
  always_comb begin
    sh      = 11'sd30 - $signed({n[9], n});
    lsh     = 6'd0;
    rnd_w   = 65'd0;
    st_next = 32'd0;
    st_of   = 1'b0;
    if (p == 64'd0) begin
      st_next = 32'd0;
    end else if (sh >= 11'sd64) begin
      st_next = 32'd0;
    end else if (sh > 11'sd0) begin
      rnd_w   = ({1'b0, p} + (65'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
      st_of   = |rnd_w[64:32];
      st_next = st_of ? PRICE_MAX : rnd_w[31:0];
    end else if (sh <= -11'sd32) begin
      st_of   = 1'b1;
      st_next = PRICE_MAX;
    end else begin
      lsh     = 6'd0 - sh[5:0];
      st_of   = (p > {32'd0, PRICE_MAX >> lsh});
      st_next = st_of ? PRICE_MAX : p[31:0] << lsh;
    end
  end

  // payoff and saturating accumulate
  assign payoff     = (st > cfg.strike) ? {32'd0, st - cfg.strike} : 64'd0;
  assign sum_w      = {1'b0, accum} + {1'b0, payoff};
  assign accum_next = sum_w[64] ? {64{1'b1}} : sum_w[63:0];
  assign sat_next   = sat | sum_w[64];
  assign seen_next  = seen + 32'd1;
  assign run_done   = (seen_next >= cfg.count);
  assign slot_free  = !res_vld || result_out.ready;
  assign res_load   = (state == S_ACC) && run_done && slot_free;

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (head.valid) z <= head.sample;
      S_D: d <= ($signed({{3{cfg.rate[17]}}, cfg.rate}) <<< 17)
               - $signed({2'd0, {18'd0, cfg.vol} * {18'd0, cfg.vol}});
      S_DT: begin
        drift  <= drift_w[31:0];
        sq_rem <= {cfg.maturity, 32'd0};
        sq_res <= 56'd0;
        sq_bit <= 56'd1 << 54;
      end
      S_SQ: if (sq_bit != 56'd0) begin
        if (sq_rem >= sq_try) begin
          sq_rem <= sq_rem - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_SV: sv <= {8'd0, sv_w[47:24]};
      S_MZ: mz <= $signed({1'b0, sv}) * z;
      S_X: begin
        if (x_w > 64'(X_LIMIT)) x <= X_LIMIT;
        else if (x_w < -64'(X_LIMIT)) x <= -X_LIMIT;
        else x <= x_w[23:0];
      end
      S_Y: begin
        n <= y_w[55:46];
        u <= y_w[45:16];
      end
      S_T: begin
        t    <= t_w[59:30];
        hacc <= ONE_Q30;
        k    <= HORNER_K0;
      end
      S_H: dvd <= h_w[61:30];
      S_DIV: plo <= dvd * mag[17:0];
      S_DIV2: begin
        hacc <= ONE_Q30 + q_w[66:35];
        k    <= k - 4'd1;
      end
      S_P:  p <= cfg.spot * hacc;
      S_SH: st <= st_next;
      S_ACC: ;
      default: ;
    endcase
  end

  // sequencer, run state and result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      accum   <= 64'd0;
      seen    <= 32'd0;
      sat     <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      if (res_load) res_vld <= 1'b1;
      else if (result_out.ready) res_vld <= 1'b0;
      unique case (state)
        S_IDLE: if (head.valid) state <= (seen == 32'd0) ? S_D : S_MZ;
        S_D:    state <= S_DT;
        S_DT:   state <= S_SQ;
        S_SQ:   if (sq_bit == 56'd0) state <= S_SV;
        S_SV:   state <= S_MZ;
        S_MZ:   state <= S_X;
        S_X:    state <= S_Y;
        S_Y:    state <= S_T;
        S_T:    state <= S_H;
        S_H:    state <= S_DIV;
        S_DIV:  state <= S_DIV2;
        S_DIV2: state <= (k == 4'd1) ? S_P : S_H;
        S_P:    state <= S_SH;
        S_SH: begin
          if (st_of) sat <= 1'b1;
          state <= S_ACC;
        end
        S_ACC: begin
          if (!run_done) begin
            accum <= accum_next;
            sat   <= sat_next;
            seen  <= seen_next;
            state <= S_IDLE;
          end else if (slot_free) begin
            res_sum <= accum_next;
            res_sat <= sat_next;
            accum   <= 64'd0;
            sat     <= 1'b0;
            seen    <= 32'd0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/ecpa_payoff_checker.sv =====
// ----------------------------------------------------------------------------
// ecpa_payoff_checker
// Watches the register port and both channels of the call payoff
// accumulator, predicts each run sum and saturation flag, and compares every
// result with the oldest pending prediction.
// ----------------------------------------------------------------------------
module ecpa_payoff_checker
  import ecpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ecpa_sample_if                smp,
  ecpa_result_if                res,
  output int                    fail_count,
  output int                    runs_pending,
  output int                    samples_seen_total,
  output int                    runs_checked
);

  typedef struct {
    logic [63:0] sum;
    logic        sat;
  } run_sum_t;

  run_sum_t    sum_q[$];

  // predictor copy of registers and run state
  ecpa_cfg_t   regs;
  logic [63:0] acc_sum;
  logic [31:0] run_seen;
  logic [31:0] drift_q16;
  logic [31:0] vol_q16;
  logic        sat_flag;

  // shift right with rounding half away from zero
  function automatic longint round_shift(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // terminal price in Q16.16; sets the run flag when it clips
  function automatic logic [31:0] price_at(longint x);
    longint      y;
    longint      n;
    longint      sh;
    logic [63:0] u;
    logic [63:0] t;
    logic [63:0] m;
    logic [63:0] p;
    logic [63:0] st;
    if (x > X_LIMIT) x = X_LIMIT;
    if (x < -X_LIMIT) x = -X_LIMIT;
    y = x * longint'(LOG2E_Q30);
    n = y >>> 46;
    u = (y & ((64'd1 << 46) - 1)) >> 16;
    t = (u * LN2_Q30) >> 30;
    m = ONE_Q30;
    for (int k = HORNER_K0; k >= 1; k--) m = ONE_Q30 + ((m * t) >> 30) / k;
    p = regs.spot * m;
    if (p == 0) return 32'd0;
    sh = 30 - n;
    if (sh >= 64) st = 0;
    else if (sh > 0) st = (p + (64'd1 << (sh - 1))) >> sh;
    else if (-sh >= 32 || p > (64'(PRICE_MAX) >> (-sh))) st = 64'(PRICE_MAX) + 1;
    else st = p << (-sh);
    if (st > PRICE_MAX) begin
      sat_flag = 1'b1;
      st       = PRICE_MAX;
    end
    return st[31:0];
  endfunction

  task automatic predict_sample(logic signed [15:0] z);
    longint      r;
    longint      s;
    longint      x;
    logic [31:0] st;
    logic [63:0] payoff;
    run_sum_t    done;
    // latch drift and scaled volatility at run start
    if (run_seen == 0) begin
      r         = longint'(regs.rate);
      s         = longint'(regs.vol);
      drift_q16 = 32'(round_shift((r * 131072 - s * s) * longint'(regs.maturity), 33));
      vol_q16   = 32'((64'(s) * int_sqrt(64'(regs.maturity) << 32) + (64'd1 << 23)) >> 24);
    end
    x  = longint'(signed'(drift_q16)) + round_shift(longint'(vol_q16) * longint'(z), 12);
    st = price_at(x);
    payoff = (st > regs.strike) ? 64'(st - regs.strike) : 64'd0;
    if (payoff > ~acc_sum) begin
      acc_sum  = '1;
      sat_flag = 1'b1;
    end else begin
      acc_sum = acc_sum + payoff;
    end
    run_seen = run_seen + 1;
    if (run_seen >= regs.count) begin
      done.sum = acc_sum;
      done.sat = sat_flag;
      sum_q.push_back(done);
      acc_sum  = 0;
      run_seen = 0;
      sat_flag = 1'b0;
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  assign runs_pending = sum_q.size();

  always @(posedge clk) begin
    run_sum_t want;
    if (rst) begin
      regs     = '{SPOT_RST, STRIKE_RST, MATURITY_RST, RATE_RST, VOL_RST, COUNT_RST};
      acc_sum  = 0;
      run_seen = 0;
      drift_q16 = 0;
      vol_q16  = 0;
      sat_flag = 1'b0;
      sum_q.delete();
      fail_count = 0;
      samples_seen_total <= 0;
      runs_checked       <= 0;
    end else begin
      // register writes; unused indexes drop
      if (cfg_we) begin
        case (cfg_index)
          REG_SPOT:     regs.spot     = cfg_data;
          REG_STRIKE:   regs.strike   = cfg_data;
          REG_MATURITY: regs.maturity = cfg_data[23:0];
          REG_RATE:     regs.rate     = cfg_data[17:0];
          REG_VOL:      regs.vol      = cfg_data[17:0];
          REG_COUNT:    regs.count    = cfg_data;
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        predict_sample(smp.normal_sample);
        samples_seen_total <= samples_seen_total + 1;
      end
      // compare a taken result with the oldest prediction
      if (res.valid && res.ready) begin
        if (sum_q.size() == 0) begin
          $display("unexpected result: sum %0h flag %0b", res.payoff_sum, res.sum_saturated);
          fail_count++;
        end else begin
          want = sum_q.pop_front();
          if (res.payoff_sum !== want.sum) report("payoff_sum", res.payoff_sum, want.sum);
          if (res.sum_saturated !== want.sat)
            report("sum_saturated", res.sum_saturated, want.sat);
          runs_checked <= runs_checked + 1;
        end
      end
    end
  end

endmodule

// ===== verif/tb_european_call_payoff_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// tb_european_call_payoff_accumulator_top
// Drives normal samples and register settings into the call payoff
// accumulator with random gaps and back pressure; the checker beside the
// block predicts and compares every run result.
// ----------------------------------------------------------------------------
module tb_european_call_payoff_accumulator_top;
  import ecpa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
  localparam int DRAIN_CYCLES = 900;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int RANDOM_ITEMS = 1100;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    runs_pending;
  int                    samples_total;
  int                    runs_total;
  int                    sent;
  int                    idle_cycles;
  bit                    calm;
  bit                    hold_req;

  ecpa_sample_if sample_ch ();
  ecpa_result_if result_ch ();

  european_call_payoff_accumulator_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_ch.sink),
    .result_out (result_ch.source)
  );

  ecpa_payoff_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .smp                (sample_ch),
    .res                (result_ch),
    .fail_count         (fail_count),
    .runs_pending       (runs_pending),
    .samples_seen_total (samples_total),
    .runs_checked       (runs_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if (calm) return 0;
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] z);
    int gap;
    sample_ch.valid         <= 1'b1;
    sample_ch.normal_sample <= z;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sent++;
    gap = gap_len();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, let every run land, then let a partial sample finish
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    int gap;
    result_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = gap_len();
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // watchdog on cycles with no request taken on either side
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int rand_sent;
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    sample_ch.valid         = 1'b0;
    sample_ch.normal_sample = '0;
    sent                    = 0;
    calm                    = 1'b1;
    hold_req                = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default settings: sample extremes
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    settle();

    // zero spot, zero strike, unused indexes ignored
    write_reg(REG_SPOT, 32'd0);
    write_reg(REG_STRIKE, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_SPARE, 32'h1234_5678);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    settle();

    // price overflow: top spot, long maturity, top volatility and rate
    write_reg(REG_SPOT, 32'hFFFF_FFFF);
    write_reg(REG_MATURITY, 32'h00FF_FFFF);
    write_reg(REG_VOL, 32'h3_FFFF);
    write_reg(REG_RATE, 32'h1_FFFF);
    write_reg(REG_COUNT, 32'd3);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    settle();

    // most negative rate, zero maturity and volatility, top strike
    write_reg(REG_RATE, 32'h2_0000);
    write_reg(REG_MATURITY, 32'd0);
    write_reg(REG_VOL, 32'd0);
    write_reg(REG_STRIKE, 32'hFFFF_FFFF);
    write_reg(REG_COUNT, 32'd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh1000);
    settle();

    // count lowered mid-run ends the run on the next sample
    write_reg(REG_SPOT, 32'd6553600);
    write_reg(REG_STRIKE, 32'd5898240);
    write_reg(REG_MATURITY, 32'd65536);
    write_reg(REG_VOL, 32'd26214);
    write_reg(REG_RATE, 32'd3277);
    write_reg(REG_COUNT, 32'hFFFF_FFFF);
    send_sample(16'sh0800);
    send_sample(16'shF800);
    send_sample(16'sh2000);
    settle();
    write_reg(REG_COUNT, 32'd2);
    send_sample(16'sh0400);
    settle();

    // back pressure: results held while samples keep coming
    write_reg(REG_COUNT, 32'd1);
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) send_sample(16'($urandom));
    settle();

    // random phases
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) write_reg(REG_SPOT,
          ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 32'd300 << 16));
      if ($urandom_range(0, 1)) write_reg(REG_STRIKE,
          ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 32'd300 << 16));
      if ($urandom_range(0, 2) == 0) write_reg(REG_MATURITY,
          ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'd5 << 16));
      if ($urandom_range(0, 2) == 0) write_reg(REG_RATE, $urandom);
      if ($urandom_range(0, 2) == 0) write_reg(REG_VOL,
          ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'd65536));
      if ($urandom_range(0, 1)) write_reg(REG_COUNT,
          ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1, 6));
      n = $urandom_range(10, 40);
      for (int i = 0; i < n; i++) send_sample(16'($urandom));
      rand_sent += n;
      settle();
    end

    $display("run: %0d samples taken, %0d run sums checked, incl. saturation,",
             samples_total, runs_total);
    $display("zero spot, count changes, ignored writes and a long result stall");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
